### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the hash core's RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/fmrh64_pkg.sv
// ---------------------------------------------------------------------------
// fmrh64_pkg
// Types, constants and the microcode store of the four-lane hash core.
// ---------------------------------------------------------------------------
package fmrh64_pkg;

    localparam int PCW = 6;

    localparam logic [63:0] K0 = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] K1 = 64'h85EBCA77C2B2AE3D;
    localparam logic [63:0] K2 = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] K3 = 64'h94D049BB133111EB;

    // Operand register load select.
    typedef enum logic [2:0] {
        XS_HOLD,
        XS_BASE,
        XS_MIX,
        XS_FOLD29,
        XS_FOLD31,
        XS_FOLD37
    } t_xsel;

    // Which 32x32 partial product the multiplier forms.
    typedef enum logic [1:0] {
        MP_IDLE,
        MP_LL,
        MP_HL,
        MP_LH
    } t_mphase;

    typedef enum logic [1:0] {
        K_0,
        K_1,
        K_2,
        K_3
    } t_ksel;

    // Product accumulator operation.
    typedef enum logic [1:0] {
        AC_HOLD,
        AC_LOAD,
        AC_ADDHI
    } t_acc;

    // Lane write select.
    typedef enum logic [2:0] {
        LW_NONE,
        LW_L0,
        LW_L1,
        LW_L2,
        LW_L3,
        LW_SEL
    } t_lwr;

    typedef enum logic [2:0] {
        J_NEXT,
        J_FETCH,
        J_SKIP_ABS,
        J_SKIP_LAST,
        J_OUT,
        J_GOTO
    } t_jmp;

    typedef struct packed {
        t_xsel            x_sel;
        t_mphase          mphase;
        t_ksel            k_sel;
        t_acc             acc;
        t_lwr             lane_wr;
        logic             out_wr;
        t_jmp             jmp;
        logic [PCW-1:0]   target;
    } t_ctrl;

    typedef struct packed {
        logic absorb;
        logic last;
        logic out_free;
    } t_status;

    localparam logic [PCW-1:0] PC_FETCH = 6'd0;
    localparam logic [PCW-1:0] PC_ABS   = 6'd23;
    localparam logic [PCW-1:0] PC_FOLD  = 6'd29;
    localparam logic [PCW-1:0] PC_OUT   = 6'd44;

    function automatic logic [63:0] k_const(input t_ksel k);
        logic [63:0] r;
        case (k)
            K_0:     r = K0;
            K_1:     r = K1;
            K_2:     r = K2;
            default: r = K3;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int r);
        return (v << r) | (v >> (64 - r));
    endfunction

    // Keeps the low cnt bytes; any count of eight or more keeps the whole word.
    function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
        logic [63:0] m;
        for (int i = 0; i < 8; i++) begin
            m[8*i +: 8] = (4'(i) < cnt) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    function automatic t_ctrl mk(input t_xsel xs, input t_mphase mp, input t_ksel ks,
                                 input t_acc ac, input t_lwr lw, input logic ow,
                                 input t_jmp j, input logic [PCW-1:0] tg);
        t_ctrl c;
        c.x_sel   = xs;
        c.mphase  = mp;
        c.k_sel   = ks;
        c.acc     = ac;
        c.lane_wr = lw;
        c.out_wr  = ow;
        c.jmp     = j;
        c.target  = tg;
        return c;
    endfunction

    // Control store. Each 64-bit multiply by a constant takes four steps:
    // low x low, then high x low and low x high folded into the upper half.
    function automatic t_ctrl ucode(input logic [PCW-1:0] pc);
        t_ctrl w;
        case (pc)
            // Fetch: on a first beat go seed the lanes, otherwise absorb.
            6'd0:  w = mk(XS_HOLD,   MP_IDLE, K_0, AC_HOLD,  LW_NONE, 1'b0, J_FETCH, PC_ABS);
            // length * K0
            6'd1:  w = mk(XS_HOLD,   MP_LL,   K_0, AC_HOLD,  LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd2:  w = mk(XS_HOLD,   MP_HL,   K_0, AC_LOAD,  LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd3:  w = mk(XS_HOLD,   MP_LH,   K_0, AC_ADDHI, LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd4:  w = mk(XS_HOLD,   MP_IDLE, K_0, AC_ADDHI, LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd5:  w = mk(XS_BASE,   MP_IDLE, K_0, AC_HOLD,  LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            // base * K0 .. K3 into the four lanes
            6'd6:  w = mk(XS_HOLD,   MP_LL,   K_0, AC_HOLD,  LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd7:  w = mk(XS_HOLD,   MP_HL,   K_0, AC_LOAD,  LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd8:  w = mk(XS_HOLD,   MP_LH,   K_0, AC_ADDHI, LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd9:  w = mk(XS_HOLD,   MP_IDLE, K_0, AC_ADDHI, LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd10: w = mk(XS_HOLD,   MP_LL,   K_1, AC_HOLD,  LW_L0,   1'b0, J_NEXT, PC_FETCH);
            6'd11: w = mk(XS_HOLD,   MP_HL,   K_1, AC_LOAD,  LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd12: w = mk(XS_HOLD,   MP_LH,   K_1, AC_ADDHI, LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd13: w = mk(XS_HOLD,   MP_IDLE, K_1, AC_ADDHI, LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd14: w = mk(XS_HOLD,   MP_LL,   K_2, AC_HOLD,  LW_L1,   1'b0, J_NEXT, PC_FETCH);
            6'd15: w = mk(XS_HOLD,   MP_HL,   K_2, AC_LOAD,  LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd16: w = mk(XS_HOLD,   MP_LH,   K_2, AC_ADDHI, LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd17: w = mk(XS_HOLD,   MP_IDLE, K_2, AC_ADDHI, LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd18: w = mk(XS_HOLD,   MP_LL,   K_3, AC_HOLD,  LW_L2,   1'b0, J_NEXT, PC_FETCH);
            6'd19: w = mk(XS_HOLD,   MP_HL,   K_3, AC_LOAD,  LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd20: w = mk(XS_HOLD,   MP_LH,   K_3, AC_ADDHI, LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd21: w = mk(XS_HOLD,   MP_IDLE, K_3, AC_ADDHI, LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd22: w = mk(XS_HOLD,   MP_IDLE, K_0, AC_HOLD,  LW_L3,   1'b0, J_NEXT, PC_FETCH);
            // Absorb one word into the routed lane.
            6'd23: w = mk(XS_MIX,    MP_IDLE, K_0, AC_HOLD,  LW_NONE, 1'b0, J_SKIP_ABS, PC_FOLD);
            6'd24: w = mk(XS_HOLD,   MP_LL,   K_0, AC_HOLD,  LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd25: w = mk(XS_HOLD,   MP_HL,   K_0, AC_LOAD,  LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd26: w = mk(XS_HOLD,   MP_LH,   K_0, AC_ADDHI, LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd27: w = mk(XS_HOLD,   MP_IDLE, K_0, AC_ADDHI, LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd28: w = mk(XS_HOLD,   MP_IDLE, K_0, AC_HOLD,  LW_SEL,  1'b0, J_NEXT, PC_FETCH);
            // Merge the lanes; without a last beat return to fetch.
            6'd29: w = mk(XS_FOLD29, MP_IDLE, K_0, AC_HOLD,  LW_NONE, 1'b0, J_SKIP_LAST, PC_FETCH);
            6'd30: w = mk(XS_HOLD,   MP_LL,   K_1, AC_HOLD,  LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd31: w = mk(XS_HOLD,   MP_HL,   K_1, AC_LOAD,  LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd32: w = mk(XS_HOLD,   MP_LH,   K_1, AC_ADDHI, LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd33: w = mk(XS_HOLD,   MP_IDLE, K_1, AC_ADDHI, LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd34: w = mk(XS_FOLD31, MP_IDLE, K_2, AC_HOLD,  LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd35: w = mk(XS_HOLD,   MP_LL,   K_2, AC_HOLD,  LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd36: w = mk(XS_HOLD,   MP_HL,   K_2, AC_LOAD,  LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd37: w = mk(XS_HOLD,   MP_LH,   K_2, AC_ADDHI, LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd38: w = mk(XS_HOLD,   MP_IDLE, K_2, AC_ADDHI, LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd39: w = mk(XS_FOLD37, MP_IDLE, K_0, AC_HOLD,  LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd40: w = mk(XS_HOLD,   MP_LL,   K_0, AC_HOLD,  LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd41: w = mk(XS_HOLD,   MP_HL,   K_0, AC_LOAD,  LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd42: w = mk(XS_HOLD,   MP_LH,   K_0, AC_ADDHI, LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            6'd43: w = mk(XS_HOLD,   MP_IDLE, K_0, AC_ADDHI, LW_NONE, 1'b0, J_NEXT, PC_FETCH);
            // Final fold into the output register once it is free.
            6'd44: w = mk(XS_HOLD,   MP_IDLE, K_0, AC_HOLD,  LW_NONE, 1'b1, J_OUT, PC_FETCH);
            default: w = mk(XS_HOLD, MP_IDLE, K_0, AC_HOLD,  LW_NONE, 1'b0, J_GOTO, PC_FETCH);
        endcase
        return w;
    endfunction

endpackage

### src/four_lane_multiply_rotate_hash64_core.sv
// ---------------------------------------------------------------------------
// four_lane_multiply_rotate_hash64_core
// Four-lane multiply-rotate 64-bit hash over a stream of message words.
// ---------------------------------------------------------------------------
// Sequencing: a word that is neither first nor last runs the absorb routine
// and returns to fetch (zero bytes skip it); a first beat adds the seeding.
// A last beat adds the finish; the hash is valid the cycle after the output step.
// The core takes a new beat only at fetch; each 64-bit multiply is four steps of one
// shared 32x32 multiplier, driven by the microcode control store.
// Reset (synchronous, active low) zeroes the lanes, counters and output valid.
module four_lane_multiply_rotate_hash64_core #(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_first,
    input  logic [63:0] i_seed,
    input  logic [31:0] i_msg_len,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_hash_value
);

    // The sequencer steps through a short program. At the fetch step the
    // input side is open; a first beat runs the seeding routine (length times
    // K0, xor seed, then the base times each of the four constants into the
    // lanes), every beat with bytes then runs the absorb routine, and a last beat runs
    // the merge and three-multiply finish before the output step.
    fmrh64_pkg::t_ctrl   ctrl;
    fmrh64_pkg::t_status status;
    logic                in_accept;

    // The input side is open only while the program sits at its fetch step.
    assign o_in_stall = (ctrl.jmp != fmrh64_pkg::J_FETCH);
    assign in_accept  = i_in_valid && !o_in_stall;

    fmrh64_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_first    (i_first),
        .i_status   (status),
        .o_ctrl     (ctrl)
    );

    // The datapath holds the lanes and the result register. The output
    // register separates the two sides: a finished hash waits there while
    // the core goes back to fetch and takes the next message's beats.
    fmrh64_datapath #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_accept     (in_accept),
        .i_first      (i_first),
        .i_seed       (i_seed),
        .i_msg_len    (i_msg_len),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .i_out_stall  (i_out_stall),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .o_hash_value (o_hash_value)
    );

endmodule

### src/fmrh64_mul.sv
// ---------------------------------------------------------------------------
// fmrh64_mul
// Shared 32x32 multiplier forming one partial product of x times a constant.
// ---------------------------------------------------------------------------
module fmrh64_mul (
    input  logic                   i_clk,
    input  logic [63:0]            i_x,
    input  fmrh64_pkg::t_mphase    i_mphase,
    input  fmrh64_pkg::t_ksel      i_k_sel,
    output logic [63:0]            o_prod
);

    logic [63:0] k_val;
    logic [31:0] a_op;
    logic [31:0] b_op;
    logic [63:0] r_prod;

    always_comb begin
        k_val = fmrh64_pkg::k_const(i_k_sel);
        a_op  = (i_mphase == fmrh64_pkg::MP_HL) ? i_x[63:32] : i_x[31:0];
        b_op  = (i_mphase == fmrh64_pkg::MP_LH) ? k_val[63:32] : k_val[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_mphase != fmrh64_pkg::MP_IDLE) begin
            r_prod <= a_op * b_op;
        end
    end

    assign o_prod = r_prod;

endmodule

### src/fmrh64_datapath.sv
// ---------------------------------------------------------------------------
// fmrh64_datapath
// Lanes, operand and product registers and the output register of the core.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fmrh64_datapath #(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fmrh64_pkg::t_ctrl    i_ctrl,
    input  logic                 i_accept,
    input  logic                 i_first,
    input  logic [63:0]          i_seed,
    input  logic [31:0]          i_msg_len,
    input  logic [63:0]          i_data_word,
    input  logic [3:0]           i_byte_count,
    input  logic                 i_last,
    input  logic                 i_out_stall,
    output fmrh64_pkg::t_status  o_status,
    output logic                 o_out_valid,
    output logic [63:0]          o_hash_value
);

    localparam int IDXW = LENGTH_WIDTH - 3;
    localparam logic [63:0] LEN_MASK =
        (LENGTH_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << LENGTH_WIDTH) - 64'd1);

    logic [63:0]     r_lane [4];
    logic [IDXW-1:0] r_widx;
    logic [IDXW-1:0] r_bw;
    logic [63:0]     r_x;
    logic [63:0]     r_y;
    logic [63:0]     r_seed;
    logic [63:0]     r_word;
    logic            r_absorb;
    logic            r_last;
    logic            r_out_valid;
    logic [63:0]     r_hash;

    logic [63:0]     prod;
    logic [63:0]     len_ext;
    logic [63:0]     bw_full;
    logic [1:0]      sel;
    logic [63:0]     rot_word;
    logic [63:0]     fold;
    logic            out_free;

    fmrh64_mul u_mul (
        .i_clk    (i_clk),
        .i_x      (r_x),
        .i_mphase (i_ctrl.mphase),
        .i_k_sel  (i_ctrl.k_sel),
        .o_prod   (prod)
    );

    always_comb begin
        len_ext  = {32'd0, i_msg_len} & LEN_MASK;
        bw_full  = (len_ext >> 5) << 2;
        sel      = (r_widx < r_bw) ? r_widx[1:0] : 2'd0;
        case (sel)
            2'd0:    rot_word = fmrh64_pkg::rotl64(r_word, 23);
            2'd1:    rot_word = fmrh64_pkg::rotl64(r_word, 47);
            2'd2:    rot_word = fmrh64_pkg::rotl64(r_word, 13);
            default: rot_word = fmrh64_pkg::rotl64(r_word, 37);
        endcase
        fold     = r_lane[0] ^ r_lane[1] ^ r_lane[2] ^ r_lane[3];
        out_free = !r_out_valid || !i_out_stall;
    end

    // Operand register: loaded with the length on a first beat, then
    // by the microcode select.
    always_ff @(posedge i_clk) begin
        if (i_accept && i_first) begin
            r_x <= len_ext;
        end else begin
            case (i_ctrl.x_sel)
                fmrh64_pkg::XS_BASE:   r_x <= r_seed ^ r_y;
                fmrh64_pkg::XS_MIX:    r_x <= r_lane[sel] ^ rot_word;
                fmrh64_pkg::XS_FOLD29: r_x <= fold ^ (fold >> 29);
                fmrh64_pkg::XS_FOLD31: r_x <= r_y ^ (r_y >> 31);
                fmrh64_pkg::XS_FOLD37: r_x <= r_y ^ (r_y >> 37);
                default:               r_x <= r_x;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.acc)
            fmrh64_pkg::AC_LOAD:  r_y <= prod;
            fmrh64_pkg::AC_ADDHI: r_y <= {r_y[63:32] + prod[31:0], r_y[31:0]};
            default:              r_y <= r_y;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_seed <= i_seed;
            r_word <= i_data_word & fmrh64_pkg::byte_mask(i_byte_count);
        end
        if (i_ctrl.out_wr && out_free) begin
            r_hash <= r_y ^ (r_y >> 41);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_lane[i] <= '0;
            end
            r_widx      <= '0;
            r_bw        <= '0;
            r_absorb    <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_absorb <= |i_byte_count;
                r_last   <= i_last;
                if (i_first) begin
                    r_widx <= '0;
                    r_bw   <= bw_full[IDXW-1:0];
                end
            end
            case (i_ctrl.lane_wr)
                fmrh64_pkg::LW_L0:  r_lane[0] <= r_y;
                fmrh64_pkg::LW_L1:  r_lane[1] <= r_y;
                fmrh64_pkg::LW_L2:  r_lane[2] <= r_y;
                fmrh64_pkg::LW_L3:  r_lane[3] <= r_y;
                fmrh64_pkg::LW_SEL: begin
                    r_lane[sel] <= r_y;
                    r_widx      <= r_widx + IDXW'(1);
                end
                default: ;
            endcase
            if (i_ctrl.out_wr && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.absorb   = r_absorb;
    assign o_status.last     = r_last;
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_hash_value      = r_hash;

    `FM_ASSERT_SAME(a_out_from_step, i_clk, i_rst_n,
        !$past(r_out_valid) && r_out_valid, $past(i_ctrl.out_wr),
        "output valid rose without an output step")
    `FM_ASSERT_SAME(a_widx_source, i_clk, i_rst_n, r_widx != $past(r_widx),
        ($past(i_ctrl.lane_wr) == fmrh64_pkg::LW_SEL) || ($past(i_accept) && $past(i_first)),
        "word index moved outside an absorb or first beat")

endmodule

### src/fmrh64_sequencer.sv
// ---------------------------------------------------------------------------
// fmrh64_sequencer
// Step counter and control store reader with conditional jumps.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fmrh64_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_first,
    input  fmrh64_pkg::t_status  i_status,
    output fmrh64_pkg::t_ctrl    o_ctrl
);

    logic [fmrh64_pkg::PCW-1:0] r_pc;
    logic [fmrh64_pkg::PCW-1:0] n_pc;
    logic [fmrh64_pkg::PCW-1:0] pc_inc;
    fmrh64_pkg::t_ctrl          ctrl;

    always_comb begin
        ctrl = fmrh64_pkg::ucode(r_pc);
    end

    always_comb begin
        pc_inc = r_pc + fmrh64_pkg::PCW'(1);
        case (ctrl.jmp)
            fmrh64_pkg::J_NEXT:      n_pc = pc_inc;
            fmrh64_pkg::J_FETCH: begin
                if (!i_in_valid) begin
                    n_pc = r_pc;
                end else begin
                    n_pc = i_first ? pc_inc : ctrl.target;
                end
            end
            fmrh64_pkg::J_SKIP_ABS:  n_pc = i_status.absorb ? pc_inc : ctrl.target;
            fmrh64_pkg::J_SKIP_LAST: n_pc = i_status.last ? pc_inc : ctrl.target;
            fmrh64_pkg::J_OUT:       n_pc = i_status.out_free ? ctrl.target : r_pc;
            default:                 n_pc = ctrl.target;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= fmrh64_pkg::PC_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = ctrl;

    `FM_ASSERT_NEXT(a_fetch_wait, i_clk, i_rst_n,
        (r_pc == fmrh64_pkg::PC_FETCH) && !i_in_valid, r_pc == fmrh64_pkg::PC_FETCH,
        "sequencer left fetch without a beat")
    `FM_ASSERT_NEXT(a_out_return, i_clk, i_rst_n,
        (r_pc == fmrh64_pkg::PC_OUT) && i_status.out_free, r_pc == fmrh64_pkg::PC_FETCH,
        "sequencer did not return to fetch after output")

endmodule

### verif/tb_four_lane_multiply_rotate_hash64_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_four_lane_multiply_rotate_hash64_core
// Self-checking bench for the four-lane multiply-rotate hash core. A queue of
// message beats feeds a clocked driver. Every accepted beat goes through a
// local model of the lanes and the finish chain. A clocked monitor compares
// each hash that leaves the core with the oldest predicted hash.
// ---------------------------------------------------------------------------
module tb_four_lane_multiply_rotate_hash64_core;

    // Stimulus volume, end-of-run drain and the hard stop for a hung core.
    localparam int ITEM_TARGET   = 1050;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1_000_000;

    // The receiver holds off for this long once, so that the core's output
    // register fills and the core then stalls its input side.
    localparam int HOLD_START  = 30;
    localparam int HOLD_CYCLES = 600;

    // One beat on the input channel, exactly as it is driven onto the ports.
    typedef struct {
        logic        first;
        logic [63:0] seed;
        logic [31:0] msg_len;
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
    } t_beat;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic        i_first      = 1'b0;
    logic [63:0] i_seed       = '0;
    logic [31:0] i_msg_len    = '0;
    logic [63:0] i_data_word  = '0;
    logic [3:0]  i_byte_count = '0;
    logic        i_last       = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic [63:0] o_hash_value;

    t_beat       stim_q[$];
    t_beat       next_beat;
    logic [63:0] pending_hashes[$];

    int beats_taken = 0;
    int total_beats = 0;
    int error_count = 0;
    int cycle_count = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    // Model state: four lanes, the count of absorbed words, and how many
    // leading words of the message are spread round-robin over the lanes.
    logic [63:0] lane_acc [0:3] = '{default: '0};
    logic [28:0] words_absorbed = '0;
    logic [28:0] block_span     = '0;

    four_lane_multiply_rotate_hash64_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_first      (i_first),
        .i_seed       (i_seed),
        .i_msg_len    (i_msg_len),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hash_value (o_hash_value)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // The upper half of the doubled word, shifted, is the left rotation.
    function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned r);
        logic [127:0] twice;
        twice = {v, v} << r;
        return twice[127:64];
    endfunction

    function automatic logic [63:0] mix_word(input logic [63:0] lane, input logic [63:0] w,
                                             input int unsigned r);
        return (lane ^ rotl(w, r)) * fmrh64_pkg::K0;
    endfunction

    // The idle schedule runs in phases keyed to the number of accepted beats:
    // none, a sparse sender, a stalling receiver, light idling on both sides,
    // and a final stretch with none.
    function automatic int send_gap_pct(input int n);
        if (n >= 150 && n < 400) begin
            return 87;
        end
        if (n >= 650 && n < 900) begin
            return 10;
        end
        return 0;
    endfunction

    function automatic int recv_stall_pct(input int n);
        if (n >= 400 && n < 650) begin
            return 87;
        end
        if (n >= 650 && n < 900) begin
            return 10;
        end
        return 0;
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Folds one accepted beat into the model and, on a last beat, queues the
    // finished hash that the core must deliver.
    task automatic absorb_beat(input logic first, input logic [63:0] seed,
                               input logic [31:0] msg_len, input logic [63:0] data,
                               input logic [3:0] count, input logic last);
        logic [63:0] base;
        logic [63:0] word;
        logic [63:0] h;
        int          bytes;
        if (first) begin
            base           = seed ^ (64'(msg_len) * fmrh64_pkg::K0);
            lane_acc[0]    = base * fmrh64_pkg::K0;
            lane_acc[1]    = base * fmrh64_pkg::K1;
            lane_acc[2]    = base * fmrh64_pkg::K2;
            lane_acc[3]    = base * fmrh64_pkg::K3;
            words_absorbed = '0;
            block_span     = {msg_len[31:5], 2'b00};
        end
        // Counts above eight mean a whole word; zero bytes absorb nothing.
        bytes = (count > 4'd8) ? 8 : int'(count);
        if (bytes != 0) begin
            word = data;
            if (bytes < 8) begin
                word &= (64'd1 << (8 * bytes)) - 64'd1;
            end
            if (words_absorbed < block_span) begin
                case (words_absorbed[1:0])
                    2'd0: lane_acc[0] = mix_word(lane_acc[0], word, 23);
                    2'd1: lane_acc[1] = mix_word(lane_acc[1], word, 47);
                    2'd2: lane_acc[2] = mix_word(lane_acc[2], word, 13);
                    default: lane_acc[3] = mix_word(lane_acc[3], word, 37);
                endcase
            end else begin
                lane_acc[0] = mix_word(lane_acc[0], word, 23);
            end
            words_absorbed = words_absorbed + 29'd1;
        end
        if (last) begin
            h = lane_acc[0] ^ lane_acc[1] ^ lane_acc[2] ^ lane_acc[3];
            h ^= h >> 29;
            h *= fmrh64_pkg::K1;
            h ^= h >> 31;
            h *= fmrh64_pkg::K2;
            h ^= h >> 37;
            h *= fmrh64_pkg::K0;
            h ^= h >> 41;
            pending_hashes.push_back(h);
        end
    endtask

    task automatic queue_beat(input logic first, input logic [63:0] seed,
                              input logic [31:0] msg_len, input logic [63:0] data,
                              input logic [3:0] count, input logic last);
        t_beat b;
        b.first   = first;
        b.seed    = seed;
        b.msg_len = msg_len;
        b.data    = data;
        b.count   = count;
        b.last    = last;
        stim_q.push_back(b);
    endtask

    // Streams a message of the given byte count with random content. The
    // declared length may differ from the streamed one, and the first or the
    // last marker may be left off to build broken sequences.
    task automatic queue_message(input logic [63:0] seed, input logic [31:0] declared,
                                 input int streamed, input bit with_first,
                                 input bit with_last);
        int words;
        int tail;
        words = (streamed + 7) / 8;
        tail  = streamed % 8;
        if (words == 0) begin
            queue_beat(with_first, seed, declared, rand64(), 4'd0, with_last);
        end else begin
            for (int w = 0; w < words; w++) begin
                queue_beat(with_first && (w == 0), seed, declared, rand64(),
                           (w == words - 1 && tail != 0) ? 4'(tail) : 4'd8,
                           with_last && (w == words - 1));
            end
        end
    endtask

    // Driver: a new beat is put up only when the bus is empty or the current
    // beat is being accepted at this edge, so a stalled beat never changes.
    // The choice to idle is rolled without looking at the stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                absorb_beat(i_first, i_seed, i_msg_len, i_data_word, i_byte_count, i_last);
                beats_taken <= beats_taken + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (stim_q.size() != 0 && $urandom_range(99) >= send_gap_pct(beats_taken)) begin
                    next_beat     = stim_q.pop_front();
                    i_first      <= next_beat.first;
                    i_seed       <= next_beat.seed;
                    i_msg_len    <= next_beat.msg_len;
                    i_data_word  <= next_beat.data;
                    i_byte_count <= next_beat.count;
                    i_last       <= next_beat.last;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // The long hold-off runs once, early, while the sender has no gaps.
    always @(posedge i_clk) begin
        if (!hold_done && beats_taken >= HOLD_START) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: every accepted hash must match the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_hashes.size() == 0) begin
                    flag_error($sformatf("hash %h arrived with none expected", o_hash_value));
                end else if (o_hash_value !== pending_hashes[0]) begin
                    flag_error($sformatf("hash_value got %h expected %h",
                                         o_hash_value, pending_hashes[0]));
                    void'(pending_hashes.pop_front());
                end else begin
                    void'(pending_hashes.pop_front());
                end
            end
            i_out_stall <= (hold_left != 0) ||
                           ($urandom_range(99) < recv_stall_pct(beats_taken));
        end
    end

    // A hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int pick;
        int sz;

        // Words with no first beat after reset go into all-zero lanes.
        queue_beat(1'b0, '0, '0, rand64(), 4'd8, 1'b0);
        queue_beat(1'b0, '0, '0, rand64(), 4'd8, 1'b1);
        // Empty messages at both seed extremes.
        queue_beat(1'b1, '0, '0, rand64(), 4'd0, 1'b1);
        queue_beat(1'b1, '1, '0, '1, 4'd0, 1'b1);
        // A lone partial word must be masked to its five low bytes.
        queue_beat(1'b1, rand64(), 32'd5, '1, 4'd5, 1'b1);
        // A count above eight takes the whole word.
        queue_beat(1'b1, rand64(), 32'd8, '1, 4'd15, 1'b1);
        // An all-zero data word.
        queue_beat(1'b1, '1, 32'd8, '0, 4'd8, 1'b1);
        // One whole block touches each of the four lanes once.
        queue_message(64'h0123_4567_89AB_CDEF, 32'd32, 32, 1'b1, 1'b1);
        // After a last beat the state is kept; a zero-byte beat mid-stream
        // changes nothing but may still close the message.
        queue_beat(1'b0, '0, '0, rand64(), 4'd9, 1'b0);
        queue_beat(1'b0, '0, '0, rand64(), 4'd0, 1'b1);
        // Largest declared length against a short stream.
        queue_beat(1'b1, '1, '1, '1, 4'd8, 1'b0);
        queue_beat(1'b0, '1, '1, rand64(), 4'd3, 1'b1);
        // One block, one extra word and a three-byte tail.
        queue_message(rand64(), 32'd43, 43, 1'b1, 1'b1);
        // Declared empty but five words streamed: all of them go to lane zero.
        queue_message(rand64(), 32'd0, 40, 1'b1, 1'b1);

        // Mostly well-formed messages of modest size, mixed with broken ones and
        // scattered noise beats.
        while (stim_q.size() < ITEM_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
                sz = ($urandom_range(9) < 7) ? $urandom_range(40) : $urandom_range(200, 41);
                queue_message(rand64(), 32'(sz), sz, 1'b1, 1'b1);
            end else if (pick < 90) begin
                sz = $urandom_range(64);
                queue_message(rand64(), $urandom, sz, $urandom_range(3) != 0,
                              $urandom_range(3) != 0);
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    queue_beat($urandom_range(3) == 0, rand64(), $urandom, rand64(),
                               4'($urandom_range(15)), $urandom_range(3) == 0);
                end
            end
        end
        total_beats = stim_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every beat accepted, every hash delivered, then a quiet
        // stretch to catch anything the core emits unasked.
        while (beats_taken < total_beats) @(posedge i_clk);
        while (pending_hashes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (pending_hashes.size() != 0) begin
            flag_error($sformatf("%0d hashes never arrived", pending_hashes.size()));
        end
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
